FILE: rtl/dual_axis_pid_deadband_clamp_unit_macros.svh
// assertion macros for the dual axis pid unit
// depends on: nothing; expects i_clk and i_rst_n in the including module
`ifndef DUAL_AXIS_PID_DEADBAND_CLAMP_UNIT_MACROS_SVH
`define DUAL_AXIS_PID_DEADBAND_CLAMP_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define DAPDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define DAPDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dapdc_pkg.sv
// shared types and constants of the dual axis pid unit
// depends on: nothing
package dapdc_pkg;

    // field widths
    localparam int ANGLE_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // pipeline depth: input, product, term, result
    localparam int PIPE_STAGES = 4;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP          = 3'd0,
        CFG_KI          = 3'd1,
        CFG_KD          = 3'd2,
        CFG_DEADBAND    = 3'd3,
        CFG_INTEG_LIMIT = 3'd4,
        CFG_OUT_LIMIT   = 3'd5
    } t_cfg_idx;

    // reset values
    localparam logic [GAIN_W-1:0]  KP_RST          = 16'd5120;
    localparam logic [GAIN_W-1:0]  KI_RST          = 16'd1280;
    localparam logic [GAIN_W-1:0]  KD_RST          = 16'd0;
    localparam logic [LIMIT_W-1:0] DEADBAND_RST    = 15'd0;
    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 15'd20;
    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST   = 15'd80;

    // configuration register file contents
    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [LIMIT_W-1:0] deadband;
        logic [LIMIT_W-1:0] integ_limit;
        logic [LIMIT_W-1:0] out_limit;
    } t_cfg;

    // stage load strobes from the pipeline control
    typedef struct packed {
        logic ld_in;
        logic ld_prod;
        logic ld_term;
        logic ld_out;
    } t_pipe_ctl;

endpackage

FILE: rtl/dapdc_cfg.sv
// configuration register file: gains, deadband and limits
// depends on: dapdc_pkg
module dapdc_cfg
    import dapdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always accepted and registered
    assign o_cfg_ready = 1'b1;

    // decode the write beat, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KP:          n_cfg.kp          = i_cfg_data;
                CFG_KI:          n_cfg.ki          = i_cfg_data;
                CFG_KD:          n_cfg.kd          = i_cfg_data;
                CFG_DEADBAND:    n_cfg.deadband    = i_cfg_data[LIMIT_W-1:0];
                CFG_INTEG_LIMIT: n_cfg.integ_limit = i_cfg_data[LIMIT_W-1:0];
                CFG_OUT_LIMIT:   n_cfg.out_limit   = i_cfg_data[LIMIT_W-1:0];
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp          <= KP_RST;
            r_cfg.ki          <= KI_RST;
            r_cfg.kd          <= KD_RST;
            r_cfg.deadband    <= DEADBAND_RST;
            r_cfg.integ_limit <= INTEG_LIMIT_RST;
            r_cfg.out_limit   <= OUT_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/dapdc_pipe_ctl.sv
// valid bits and load strobes of the four-stage pipeline
// depends on: dapdc_pkg
module dapdc_pipe_ctl
    import dapdc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_pipe_ctl              o_ctl,
    output logic [PIPE_STAGES-1:0] o_stage_valid
);

    logic [PIPE_STAGES-1:0] r_v;
    logic [PIPE_STAGES-1:0] n_v;
    logic [PIPE_STAGES-1:0] w_go;
    logic [PIPE_STAGES-1:0] w_rdy;
    logic [PIPE_STAGES-1:0] w_ld;

    // a stage can take a beat when empty or when its beat moves on
    always_comb begin
        w_go[PIPE_STAGES-1]  = i_ready;
        w_rdy[PIPE_STAGES-1] = !r_v[PIPE_STAGES-1] || i_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            w_go[k]  = w_rdy[k+1];
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    // load strobes and next valid bits
    always_comb begin
        w_ld[0] = i_valid && w_rdy[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            w_ld[k] = r_v[k-1] && w_rdy[k];
        end
        for (int k = 0; k < PIPE_STAGES; k++) begin
            n_v[k] = w_ld[k] || (r_v[k] && !w_go[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ready       = w_rdy[0];
    assign o_valid       = r_v[PIPE_STAGES-1];
    assign o_stage_valid = r_v;
    assign o_ctl.ld_in   = w_ld[0];
    assign o_ctl.ld_prod = w_ld[1];
    assign o_ctl.ld_term = w_ld[2];
    assign o_ctl.ld_out  = w_ld[3];

endmodule

FILE: rtl/dapdc_axis.sv
// pid datapath of one axis: error, deadband, products, integral, clamp, drive
// depends on: dapdc_pkg; strobes from dapdc_pipe_ctl
module dapdc_axis
    import dapdc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  t_pipe_ctl                  i_ctl,
    input  logic signed [ANGLE_W-1:0]  i_measured,
    input  logic signed [ANGLE_W-1:0]  i_target,
    output logic signed [ANGLE_W-1:0]  o_drive
);

    // input stage
    logic signed [15:0] r_measured;
    logic signed [15:0] r_target;

    // error stage logic
    logic signed [16:0] w_err;
    logic        [16:0] w_abs;
    logic signed [16:0] w_err_db;
    logic signed [17:0] w_diff;
    logic signed [33:0] w_p;
    logic signed [33:0] w_kie;
    logic signed [34:0] w_d;

    // product stage and error history
    logic signed [16:0] r_prev_err;
    logic signed [33:0] r_p;
    logic signed [33:0] r_kie;
    logic signed [34:0] r_d;

    // integral stage logic
    logic signed [34:0] w_isum;
    logic signed [34:0] w_ilim;
    logic signed [31:0] w_i;

    // term stage and integral state
    logic signed [31:0] r_acc;
    logic signed [33:0] r_pt;
    logic signed [31:0] r_it;
    logic signed [34:0] r_dt;

    // output stage logic
    logic signed [36:0] w_sum;
    logic signed [36:0] w_olim;
    logic signed [31:0] w_sc;
    logic signed [32:0] w_adj;
    logic signed [15:0] w_q;

    logic signed [15:0] r_drive;

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_measured <= i_measured;
            r_target   <= i_target;
        end
    end

    // error, deadband (edge value kept), derivative difference, products
    always_comb begin
        w_err    = 17'(r_target) - 17'(r_measured);
        w_abs    = w_err[16] ? 17'(-w_err) : 17'(w_err);
        w_err_db = (w_abs < {2'b00, i_cfg.deadband}) ? 17'sd0 : w_err;
        w_diff   = 18'(w_err_db) - 18'(r_prev_err);
        w_p      = $signed({1'b0, i_cfg.kp}) * w_err_db;
        w_kie    = $signed({1'b0, i_cfg.ki}) * w_err_db;
        w_d      = $signed({1'b0, i_cfg.kd}) * w_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (i_ctl.ld_prod) begin
            r_prev_err <= w_err_db;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_p   <= w_p;
            r_kie <= w_kie;
            r_d   <= w_d;
        end
    end

    // integral accumulate and clamp to +-integ_limit in q.16
    always_comb begin
        w_isum = 35'(r_acc) + 35'(r_kie);
        w_ilim = $signed({4'b0000, i_cfg.integ_limit, 16'h0000});
        if (w_isum > w_ilim) begin
            w_i = 32'(w_ilim);
        end else if (w_isum < -w_ilim) begin
            w_i = 32'(-w_ilim);
        end else begin
            w_i = 32'(w_isum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.ld_term) begin
            r_acc <= w_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_term) begin
            r_pt <= r_p;
            r_it <= w_i;
            r_dt <= r_d;
        end
    end

    // sum, clamp to +-out_limit, truncate toward zero, negate
    always_comb begin
        w_sum  = 37'(r_pt) + 37'(r_it) + 37'(r_dt);
        w_olim = $signed({6'b000000, i_cfg.out_limit, 16'h0000});
        if (w_sum > w_olim) begin
            w_sc = 32'(w_olim);
        end else if (w_sum < -w_olim) begin
            w_sc = 32'(-w_olim);
        end else begin
            w_sc = 32'(w_sum);
        end
        w_adj = 33'(w_sc) + (w_sc[31] ? 33'sd65535 : 33'sd0);
        w_q   = w_adj[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            r_drive <= 16'(-w_q);
        end
    end

    assign o_drive = r_drive;

endmodule

FILE: rtl/dual_axis_pid_deadband_clamp_unit.sv
// Two-axis positional PID with deadband and clamped integral. Each input beat
// (measured and target angle per axis, Q7.8) yields one result beat with the
// negated, clamped drive per axis in whole units. The datapath is a four-stage
// pipeline (input register, product register, term register, result register)
// that takes one beat per clock while the output side is not stalled. The
// integral add and clamp sit in one stage and are combinational, so the
// integral state of each axis is ready for the next beat in the following
// cycle. No clearing pass is needed after reset. Configuration writes are
// registered; the user must issue them in idle periods only, as the block
// itself does not enforce it.
// depends on: dapdc_pkg, dapdc_cfg, dapdc_pipe_ctl, dapdc_axis, macros header
`include "dual_axis_pid_deadband_clamp_unit_macros.svh"

module dual_axis_pid_deadband_clamp_unit
    import dapdc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [ANGLE_W-1:0]  i_measured_x,
    input  logic signed [ANGLE_W-1:0]  i_measured_y,
    input  logic signed [ANGLE_W-1:0]  i_target_x,
    input  logic signed [ANGLE_W-1:0]  i_target_y,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [ANGLE_W-1:0]  o_drive_x,
    output logic signed [ANGLE_W-1:0]  o_drive_y,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DAT_W-1:0]       i_cfg_data
);

    t_cfg                   w_cfg;
    t_pipe_ctl              w_ctl;
    logic [PIPE_STAGES-1:0] w_stage_valid;

    // register file
    dapdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // pipeline flow control shared by both axes
    dapdc_pipe_ctl u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ctl         (w_ctl),
        .o_stage_valid (w_stage_valid)
    );

    // x axis datapath
    dapdc_axis u_axis_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_ctl      (w_ctl),
        .i_measured (i_measured_x),
        .i_target   (i_target_x),
        .o_drive    (o_drive_x)
    );

    // y axis datapath
    dapdc_axis u_axis_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_ctl      (w_ctl),
        .i_measured (i_measured_y),
        .i_target   (i_target_y),
        .o_drive    (o_drive_y)
    );

    // input side only backs up when every stage is full and the result stalls
    `DAPDC_ASSERT_NOW(a_ready_only_when_full, !o_ready, (&w_stage_valid) && !i_ready, "input stalled with room in the pipeline")

    // an accepted beat always occupies the input stage next cycle
    `DAPDC_ASSERT_NEXT(a_accept_fills_stage, i_valid && o_ready, w_stage_valid[0], "accepted beat lost at the input stage")

    // truncated drive never reaches the most negative code
    `DAPDC_ASSERT_NOW(a_drive_range, o_valid, (o_drive_x != 16'sh8000) && (o_drive_y != 16'sh8000), "drive out of symmetric range")

endmodule

FILE: dv/tb_dual_axis_pid_deadband_clamp_unit.sv
// self-checking testbench for the dual axis pid unit: drives angle beats, predicts drives
// depends on: dapdc_pkg and dual_axis_pid_deadband_clamp_unit from rtl
module tb_dual_axis_pid_deadband_clamp_unit
    import dapdc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // indexes past the register file, the block drops writes to them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int RST_CYCLES       = 8;
    localparam int WATCHDOG_CYCLES  = 2000;
    localparam int PARK_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 16;
    localparam int REPORT_MAX       = 10;
    localparam int PHASE_BEATS      = 150;
    localparam int ANGLE_MAX        = 32767;
    localparam int ANGLE_MIN        = -32768;
    localparam int GAIN_MAX         = 65535;
    localparam int LIMIT_MAX        = 32767;

    typedef struct {
        logic signed [ANGLE_W-1:0] meas_x;
        logic signed [ANGLE_W-1:0] meas_y;
        logic signed [ANGLE_W-1:0] tgt_x;
        logic signed [ANGLE_W-1:0] tgt_y;
    } t_angle_set;

    typedef struct {
        logic signed [ANGLE_W-1:0] drv_x;
        logic signed [ANGLE_W-1:0] drv_y;
    } t_drive_pair;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [ANGLE_W-1:0]  i_measured_x = '0;
    logic signed [ANGLE_W-1:0]  i_measured_y = '0;
    logic signed [ANGLE_W-1:0]  i_target_x = '0;
    logic signed [ANGLE_W-1:0]  i_target_y = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [ANGLE_W-1:0]  o_drive_x;
    logic signed [ANGLE_W-1:0]  o_drive_y;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]       i_cfg_data = '0;

    dual_axis_pid_deadband_clamp_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_measured_x (i_measured_x),
        .i_measured_y (i_measured_y),
        .i_target_x   (i_target_x),
        .i_target_y   (i_target_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_drive_x    (o_drive_x),
        .o_drive_y    (o_drive_y),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // controller copy: registers and per-axis state
    logic [GAIN_W-1:0]  cfg_kp          = KP_RST;
    logic [GAIN_W-1:0]  cfg_ki          = KI_RST;
    logic [GAIN_W-1:0]  cfg_kd          = KD_RST;
    logic [LIMIT_W-1:0] cfg_deadband    = DEADBAND_RST;
    logic [LIMIT_W-1:0] cfg_integ_limit = INTEG_LIMIT_RST;
    logic [LIMIT_W-1:0] cfg_out_limit   = OUT_LIMIT_RST;
    longint             integ_q16 [2]   = '{0, 0};
    longint             last_err [2]    = '{0, 0};

    t_angle_set  angle_q [$];
    t_drive_pair drive_q [$];
    t_angle_set  next_set;
    t_angle_set  took_set;
    t_drive_pair want;

    bit in_taken = 1'b0;
    bit idle_en  = 1'b1;
    bit park_req = 1'b0;
    bit park_done = 1'b0;
    int park_cnt = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int bad_count = 0;
    int quiet_cycles = 0;
    int pushed_cnt = 0;
    int taken_cnt = 0;

    function automatic longint sat(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // one pid step for one axis, updates that axis's integral and last error
    function automatic logic signed [ANGLE_W-1:0] axis_drive(input int ax,
            input logic signed [ANGLE_W-1:0] meas, input logic signed [ANGLE_W-1:0] tgt);
        longint err, db, p_t, i_t, d_t, total;
        err = longint'(tgt) - longint'(meas);
        db = longint'(cfg_deadband);
        // strictly inside the deadband counts as no error
        if (err < db && err > -db) err = 0;
        p_t = longint'(cfg_kp) * err;
        i_t = sat(integ_q16[ax] + longint'(cfg_ki) * err, longint'(cfg_integ_limit) * 65536);
        d_t = longint'(cfg_kd) * (err - last_err[ax]);
        integ_q16[ax] = i_t;
        last_err[ax] = err;
        total = sat(p_t + i_t + d_t, longint'(cfg_out_limit) * 65536);
        // truncate toward zero, then negate
        return ANGLE_W'(-(total / 65536));
    endfunction

    function automatic logic signed [ANGLE_W-1:0] to_angle(input int v);
        if (v > ANGLE_MAX) return ANGLE_W'(ANGLE_MAX);
        if (v < ANGLE_MIN) return ANGLE_W'(ANGLE_MIN);
        return ANGLE_W'(v);
    endfunction

    function automatic int unsigned reg_pick(input int unsigned top);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    // input driver: one beat per handshake, random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // hold the beat until it is taken
        end else if (src_gap != 0) begin
            i_valid <= 1'b0;
            src_gap <= src_gap - 1;
        end else if (idle_en && angle_q.size() != 0 && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            src_gap <= $urandom_range(0, 11);
        end else if (angle_q.size() != 0) begin
            next_set = angle_q.pop_front();
            i_measured_x <= next_set.meas_x;
            i_measured_y <= next_set.meas_y;
            i_target_x <= next_set.tgt_x;
            i_target_y <= next_set.tgt_y;
            i_valid <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result receiver: one long park when asked, otherwise random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (park_req && !park_done) begin
            i_ready <= 1'b0;
            park_cnt <= park_cnt + 1;
            if (park_cnt == PARK_CYCLES - 1) park_done <= 1'b1;
        end else if (sink_gap != 0) begin
            i_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            i_ready <= 1'b0;
            sink_gap <= $urandom_range(0, 11);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // predict on input beats, check result beats, watch for a hang
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                took_set.meas_x = i_measured_x;
                took_set.meas_y = i_measured_y;
                took_set.tgt_x = i_target_x;
                took_set.tgt_y = i_target_y;
                want.drv_x = axis_drive(0, took_set.meas_x, took_set.tgt_x);
                want.drv_y = axis_drive(1, took_set.meas_y, took_set.tgt_y);
                drive_q.push_back(want);
                taken_cnt = taken_cnt + 1;
            end
            if (o_valid && i_ready) begin
                if (drive_q.size() == 0) begin
                    if (bad_count < REPORT_MAX)
                        $display("unexpected result beat: drive_x %0d drive_y %0d",
                                 o_drive_x, o_drive_y);
                    bad_count = bad_count + 1;
                end else begin
                    want = drive_q.pop_front();
                    if (o_drive_x !== want.drv_x) begin
                        if (bad_count < REPORT_MAX)
                            $display("drive_x mismatch: expected %0d, got %0d",
                                     want.drv_x, o_drive_x);
                        bad_count = bad_count + 1;
                    end
                    if (o_drive_y !== want.drv_y) begin
                        if (bad_count < REPORT_MAX)
                            $display("drive_y mismatch: expected %0d, got %0d",
                                     want.drv_y, o_drive_y);
                        bad_count = bad_count + 1;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // register write, mirrored into the controller copy once taken
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= dat;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KP:          cfg_kp = dat;
            CFG_KI:          cfg_ki = dat;
            CFG_KD:          cfg_kd = dat;
            CFG_DEADBAND:    cfg_deadband = dat[LIMIT_W-1:0];
            CFG_INTEG_LIMIT: cfg_integ_limit = dat[LIMIT_W-1:0];
            CFG_OUT_LIMIT:   cfg_out_limit = dat[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input int unsigned kp, input int unsigned ki, input int unsigned kd,
            input int unsigned db, input int unsigned ilim, input int unsigned olim);
        cfg_write(CFG_KP, CFG_DAT_W'(kp));
        cfg_write(CFG_KI, CFG_DAT_W'(ki));
        cfg_write(CFG_KD, CFG_DAT_W'(kd));
        cfg_write(CFG_DEADBAND, CFG_DAT_W'(db));
        cfg_write(CFG_INTEG_LIMIT, CFG_DAT_W'(ilim));
        cfg_write(CFG_OUT_LIMIT, CFG_DAT_W'(olim));
    endtask

    // wait until every queued beat is accepted and every drive has come back
    task automatic drain();
        while (taken_cnt != pushed_cnt || i_valid || drive_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic push_angles(input logic signed [ANGLE_W-1:0] mx,
            input logic signed [ANGLE_W-1:0] my, input logic signed [ANGLE_W-1:0] tx,
            input logic signed [ANGLE_W-1:0] ty);
        t_angle_set s;
        s.meas_x = mx;
        s.meas_y = my;
        s.tgt_x = tx;
        s.tgt_y = ty;
        angle_q.push_back(s);
        pushed_cnt = pushed_cnt + 1;
    endtask

    // beat with a chosen error per axis around a random working point
    task automatic push_err(input int ex, input int ey);
        int bx, by;
        bx = int'($urandom_range(0, 2000)) - 1000 - ex / 2;
        by = int'($urandom_range(0, 2000)) - 1000 - ey / 2;
        push_angles(to_angle(bx), to_angle(by), to_angle(bx + ex), to_angle(by + ey));
    endtask

    // errors right around the deadband edge
    task automatic push_edge();
        int ex, ey;
        ex = int'(cfg_deadband) + int'($urandom_range(0, 2)) - 1;
        ey = int'(cfg_deadband) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 0) ex = -ex;
        if ($urandom_range(0, 1) == 0) ey = -ey;
        push_err(ex, ey);
    endtask

    // fixed target with the measurement closing in on it, as a real loop would
    task automatic push_track_run(input int len);
        int tx, ty, mx, my;
        tx = int'($urandom_range(0, 40000)) - 20000;
        ty = int'($urandom_range(0, 40000)) - 20000;
        mx = tx + int'($urandom_range(0, 8192)) - 4096;
        my = ty + int'($urandom_range(0, 8192)) - 4096;
        repeat (len) begin
            push_angles(to_angle(mx), to_angle(my), to_angle(tx), to_angle(ty));
            mx = mx + (tx - mx) / 2 + int'($urandom_range(0, 6)) - 3;
            my = my + (ty - my) / 2 + int'($urandom_range(0, 6)) - 3;
        end
    endtask

    task automatic run_random_phase(input int beats);
        int made, len;
        made = 0;
        while (made < beats) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = $urandom_range(4, 16);
                    push_track_run(len);
                    made = made + len;
                end
                6, 7: begin
                    push_angles(ANGLE_W'($urandom), ANGLE_W'($urandom),
                                ANGLE_W'($urandom), ANGLE_W'($urandom));
                    made = made + 1;
                end
                default: begin
                    push_edge();
                    made = made + 1;
                end
            endcase
        end
    endtask

    // moderate gains so that results are not always at the limits
    task automatic set_moderate();
        set_regs($urandom_range(0, 4096), $urandom_range(0, 512), $urandom_range(0, 4096),
                 $urandom_range(0, 256), $urandom_range(1, 2000), $urandom_range(1, LIMIT_MAX));
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero, full-scale and small errors
        push_angles('0, '0, '0, '0);
        push_angles(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        push_angles(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        push_err(1, -1);
        push_err(256, -256);
        drain();

        // deadband edge: exactly on the edge is kept, just inside is zeroed
        set_regs(256, 64, 512, 100, 1000, LIMIT_MAX);
        push_err(100, -100);
        push_err(99, -99);
        push_err(-101, 101);
        push_err(0, 100);
        push_err(-100, 99);
        drain();

        // zero limits force zero drive; writes past the register file are dropped
        set_regs(GAIN_MAX, GAIN_MAX, 16'hffff, 0, 0, 0);
        cfg_write(CFG_SPARE_LO, 16'h1234);
        cfg_write(CFG_SPARE_HI, 16'hffff);
        push_err(3000, -3000);
        push_err(-12000, 7);
        push_angles(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        drain();

        // limit writes with the top bit set are masked to 15 bits
        cfg_write(CFG_OUT_LIMIT, 16'hffff);
        cfg_write(CFG_INTEG_LIMIT, 16'h8005);
        cfg_write(CFG_DEADBAND, 16'hffff);
        push_angles(16'shc000, 16'sh7fff, 16'sh3fff, 16'sh7fff);
        push_angles(16'shc000, 16'sh7ffe, 16'sh3ffe, 16'sh0000);
        push_angles(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        drain();

        // random traffic at a random moderate register setting
        set_moderate();
        run_random_phase(PHASE_BEATS);
        drain();

        // receiver parks while the sender keeps offering beats
        set_moderate();
        park_req = 1'b1;
        run_random_phase(PHASE_BEATS);
        drain();

        set_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
        run_random_phase(PHASE_BEATS);
        drain();

        set_regs(0, 0, GAIN_MAX, 0, 0, LIMIT_MAX);
        run_random_phase(PHASE_BEATS);
        drain();

        set_regs(reg_pick(GAIN_MAX), reg_pick(GAIN_MAX), reg_pick(GAIN_MAX),
                 $urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                 $urandom_range(0, GAIN_MAX));
        cfg_write(CFG_SPARE_LO, CFG_DAT_W'($urandom));
        cfg_write(CFG_SPARE_HI, CFG_DAT_W'($urandom));
        run_random_phase(PHASE_BEATS);
        drain();

        // last stretch runs at full rate on both sides
        set_moderate();
        idle_en = 1'b0;
        run_random_phase(PHASE_BEATS);
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_count == 0 && drive_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dapdc_pkg.sv
rtl/dapdc_cfg.sv
rtl/dapdc_pipe_ctl.sv
rtl/dapdc_axis.sv
rtl/dual_axis_pid_deadband_clamp_unit.sv
dv/tb_dual_axis_pid_deadband_clamp_unit.sv
